FILE: sv/ymcrc_pkg.sv
// ----------------------------------------------------------------------------
// ymcrc_pkg
// Shared types, codes and constants of the YMODEM-CRC receiver.
// ----------------------------------------------------------------------------
package ymcrc_pkg;

  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_CAN = 8'h18;
  localparam logic [7:0] BYTE_C   = 8'h43;
  localparam logic [7:0] INV_SUM  = 8'hFF;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] MAX_TIMEOUTS_RST = 8'd10;
  localparam logic [7:0] HDR_LIMIT_RST    = 8'd10;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FN_BYTE    = 2'd0,
    FN_TIMEOUT = 2'd1,
    FN_START   = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    REG_MAX_TIMEOUTS = 1'b0,
    REG_HDR_LIMIT    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_RECV   = 3'd2,
    PH_DONE   = 3'd3,
    PH_ERROR  = 3'd4,
    PH_CANCEL = 3'd5,
    PH_HFAIL  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    FR_START   = 3'd0,
    FR_NUM     = 3'd1,
    FR_INV     = 3'd2,
    FR_PAYLOAD = 3'd3,
    FR_CRC_HI  = 3'd4,
    FR_CRC_LO  = 3'd5
  } frame_t;

  typedef enum logic [1:0] {
    HF_NAME  = 2'd0,
    HF_SIZE  = 2'd1,
    HF_END   = 2'd2,
    HF_EMPTY = 2'd3
  } hfield_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        response_valid;
    logic [7:0]  response_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        data_in_file;
    logic        block_done;
    logic        block_good;
    logic [2:0]  session_state;
    logic [31:0] decl_size;
    logic [31:0] rcvd_bytes;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: sv/ymodem_crc_receiver_unit.sv
// ----------------------------------------------------------------------------
// ymodem_crc_receiver_unit
// YMODEM-CRC receiver with an item queue in front of the protocol engine.
//
//   Channel  Direction  Content
//   in_      input      func, rx_byte
//   out_     output     response, data byte, block verdict, session status
//   cfg_     APB        max_timeouts at 0x0, header_attempts_limit at 0x4
//
// One item per cycle is sustained while out_ready takes each result.
// An accepted item is held in a queue entry, then its result is registered in the engine.
// While a result waits for out_ready, the two-entry queue fills and then in_ready drops.
// Reset is synchronous and returns the session to idle with default limits.
// ----------------------------------------------------------------------------
module ymodem_crc_receiver_unit #(
  parameter int QueueDepth = ymcrc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_response_valid,
  output logic [7:0]  out_response_byte,
  output logic        out_data_valid,
  output logic [7:0]  out_data_byte,
  output logic        out_data_in_file,
  output logic        out_block_done,
  output logic        out_block_good,
  output logic [2:0]  out_session_state,
  output logic [31:0] out_decl_size,
  output logic [31:0] out_rcvd_bytes,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ymcrc_pkg::item_t   in_item, q_item;
  ymcrc_pkg::result_t res;
  logic q_valid, q_ready;
  logic [7:0] maxto_r, hlim_r;
  logic wr;

  assign in_item.func    = ymcrc_pkg::func_t'(in_func);
  assign in_item.rx_byte = in_rx_byte;
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxto_r <= ymcrc_pkg::MAX_TIMEOUTS_RST;
      hlim_r  <= ymcrc_pkg::HDR_LIMIT_RST;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == ymcrc_pkg::REG_MAX_TIMEOUTS) maxto_r <= cfg_pwdata[7:0];
      else hlim_r <= cfg_pwdata[7:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      case (ymcrc_pkg::reg_idx_t'(cfg_paddr[2]))
        ymcrc_pkg::REG_MAX_TIMEOUTS: cfg_prdata = {24'd0, maxto_r};
        ymcrc_pkg::REG_HDR_LIMIT:    cfg_prdata = {24'd0, hlim_r};
        default:                     cfg_prdata = '0;
      endcase
    end
  end

  ymcrc_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  ymcrc_engine u_engine (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .max_timeouts(maxto_r), .hdr_limit(hlim_r),
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign out_response_valid = res.response_valid;
  assign out_response_byte  = res.response_byte;
  assign out_data_valid     = res.data_valid;
  assign out_data_byte      = res.data_byte;
  assign out_data_in_file   = res.data_in_file;
  assign out_block_done     = res.block_done;
  assign out_block_good     = res.block_good;
  assign out_session_state  = res.session_state;
  assign out_decl_size      = res.decl_size;
  assign out_rcvd_bytes     = res.rcvd_bytes;

endmodule

FILE: sv/ymcrc_front.sv
// ----------------------------------------------------------------------------
// ymcrc_front
// Accepts input items and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module ymcrc_front #(
  parameter int Depth = ymcrc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ymcrc_pkg::item_t in_item,
  output logic             q_valid,
  input  logic             q_ready,
  output ymcrc_pkg::item_t q_item
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  ymcrc_pkg::item_t mem_r [Depth];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic push, pop;

  assign in_ready = (cnt_r != (AW+1)'(Depth));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
    end
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

endmodule

FILE: sv/ymcrc_engine.sv
// ----------------------------------------------------------------------------
// ymcrc_engine
// Protocol engine: one queued item per cycle, while res_ready takes each result, into a registered result.
// ----------------------------------------------------------------------------
module ymcrc_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  ymcrc_pkg::item_t   q_item,
  input  logic [7:0]         max_timeouts,
  input  logic [7:0]         hdr_limit,
  output logic               res_valid,
  input  logic               res_ready,
  output ymcrc_pkg::result_t res
);

  ymcrc_pkg::phase_t  ph_r, ph_nxt;
  ymcrc_pkg::frame_t  fr_r, fr_nxt;
  ymcrc_pkg::hfield_t hf_r, hf_nxt;
  logic [9:0]  pc_r, pc_nxt;
  logic        long_r, long_nxt;
  logic [7:0]  bn_r, bn_nxt, bi_r, bi_nxt, exp_r, exp_nxt, to_r, to_nxt, ht_r, ht_nxt;
  logic [15:0] crc_r, crc_nxt, crx_r, crx_nxt;
  logic [31:0] sz_r, sz_nxt, acc_r, acc_nxt;
  logic        rv_r;
  ymcrc_pkg::result_t res_r, o;

  logic        fire, hdr;
  logic [7:0]  b;
  logic [10:0] psize;
  logic [31:0] remain, take;
  logic [10:0] pc_inc;
  logic [15:0] crc_full;
  logic [8:0]  inv_sum;
  logic [7:0]  ht_inc, to_inc;

  assign q_ready   = !rv_r || res_ready;
  assign fire      = q_valid && q_ready;
  assign res_valid = rv_r;
  assign res       = res_r;

  always_comb begin
    b       = q_item.rx_byte;
    hdr     = (ph_r == ymcrc_pkg::PH_HEADER);
    psize   = long_r ? 11'd1024 : 11'd128;
    remain  = sz_r - acc_r;
    take    = (remain < {21'd0, psize}) ? remain : {21'd0, psize};
    pc_inc  = {1'b0, pc_r} + 11'd1;
    crc_full = {crx_r[15:8], b};
    inv_sum = {1'b0, bn_r} + {1'b0, bi_r};
    ht_inc  = ht_r + 8'd1;
    to_inc  = to_r + 8'd1;
    ph_nxt = ph_r; fr_nxt = fr_r; hf_nxt = hf_r; pc_nxt = pc_r; long_nxt = long_r;
    bn_nxt = bn_r; bi_nxt = bi_r; exp_nxt = exp_r; to_nxt = to_r; ht_nxt = ht_r;
    crc_nxt = crc_r; crx_nxt = crx_r; sz_nxt = sz_r; acc_nxt = acc_r;
    o = '0;
    case (q_item.func)
      ymcrc_pkg::FN_START: begin
        ph_nxt = ymcrc_pkg::PH_HEADER; fr_nxt = ymcrc_pkg::FR_START;
        pc_nxt = '0; long_nxt = 1'b0; bn_nxt = '0; bi_nxt = '0;
        crc_nxt = ymcrc_pkg::CRC_INIT; crx_nxt = '0; exp_nxt = 8'd1;
        to_nxt = '0; ht_nxt = '0; sz_nxt = '0; acc_nxt = '0;
        hf_nxt = ymcrc_pkg::HF_NAME;
        o.response_valid = 1'b1; o.response_byte = ymcrc_pkg::BYTE_C;
      end
      ymcrc_pkg::FN_TIMEOUT: begin
        if (hdr) begin
          ht_nxt = ht_inc; fr_nxt = ymcrc_pkg::FR_START;
          o.response_valid = 1'b1; o.response_byte = ymcrc_pkg::BYTE_C;
          if (ht_inc >= hdr_limit) ph_nxt = ymcrc_pkg::PH_HFAIL;
        end else if (ph_r == ymcrc_pkg::PH_RECV) begin
          o.block_done = (fr_r != ymcrc_pkg::FR_START);
          fr_nxt = ymcrc_pkg::FR_START;
          to_nxt = to_inc;
          o.response_valid = 1'b1;
          if (to_inc >= max_timeouts) begin
            o.response_byte = ymcrc_pkg::BYTE_CAN; ph_nxt = ymcrc_pkg::PH_ERROR;
          end else begin
            o.response_byte = ymcrc_pkg::BYTE_NAK;
          end
        end
      end
      ymcrc_pkg::FN_BYTE: begin
        if (hdr || ph_r == ymcrc_pkg::PH_RECV) begin
          case (fr_r)
            ymcrc_pkg::FR_START: begin
              if (b == ymcrc_pkg::BYTE_SOH || b == ymcrc_pkg::BYTE_STX) begin
                long_nxt = (b == ymcrc_pkg::BYTE_STX);
                fr_nxt = ymcrc_pkg::FR_NUM; pc_nxt = '0;
                crc_nxt = ymcrc_pkg::CRC_INIT; hf_nxt = ymcrc_pkg::HF_NAME;
                if (hdr) sz_nxt = '0;
              end else if (hdr) begin
                ht_nxt = ht_inc;
                o.response_valid = 1'b1; o.response_byte = ymcrc_pkg::BYTE_C;
                if (ht_inc >= hdr_limit) ph_nxt = ymcrc_pkg::PH_HFAIL;
              end else if (b == ymcrc_pkg::BYTE_EOT) begin
                o.response_valid = 1'b1; o.response_byte = ymcrc_pkg::BYTE_ACK;
                ph_nxt = ymcrc_pkg::PH_DONE;
              end else if (b == ymcrc_pkg::BYTE_CAN) begin
                ph_nxt = ymcrc_pkg::PH_CANCEL;
              end else begin
                o.response_valid = 1'b1; o.response_byte = ymcrc_pkg::BYTE_NAK;
              end
            end
            ymcrc_pkg::FR_NUM: begin
              bn_nxt = b; fr_nxt = ymcrc_pkg::FR_INV;
            end
            ymcrc_pkg::FR_INV: begin
              bi_nxt = b; fr_nxt = ymcrc_pkg::FR_PAYLOAD;
            end
            ymcrc_pkg::FR_PAYLOAD: begin
              crc_nxt = ymcrc_pkg::crc_byte(crc_r, b);
              if (hdr) begin
                if (pc_r == '0 && b == 8'h00) begin
                  hf_nxt = ymcrc_pkg::HF_EMPTY;
                end else if (hf_r == ymcrc_pkg::HF_NAME) begin
                  if (b == 8'h00) hf_nxt = ymcrc_pkg::HF_SIZE;
                end else if (hf_r == ymcrc_pkg::HF_SIZE) begin
                  if (b >= 8'h30 && b <= 8'h39) begin
                    sz_nxt = (sz_r << 3) + (sz_r << 1) + {28'd0, b[3:0]};
                  end else begin
                    hf_nxt = ymcrc_pkg::HF_END;
                  end
                end
              end else begin
                o.data_valid = 1'b1; o.data_byte = b;
                o.data_in_file = ({22'd0, pc_r} < remain);
              end
              pc_nxt = pc_inc[9:0];
              if (pc_inc >= psize) fr_nxt = ymcrc_pkg::FR_CRC_HI;
            end
            ymcrc_pkg::FR_CRC_HI: begin
              crx_nxt = {b, 8'h00}; fr_nxt = ymcrc_pkg::FR_CRC_LO;
            end
            default: begin
              crx_nxt = crc_full; fr_nxt = ymcrc_pkg::FR_START;
              o.response_valid = 1'b1;
              if (hdr) begin
                if (crc_full != crc_r) begin
                  ht_nxt = ht_inc; o.response_byte = ymcrc_pkg::BYTE_C;
                  if (ht_inc >= hdr_limit) ph_nxt = ymcrc_pkg::PH_HFAIL;
                end else begin
                  o.response_byte = ymcrc_pkg::BYTE_ACK;
                  if (hf_r == ymcrc_pkg::HF_EMPTY) begin
                    sz_nxt = '0; ph_nxt = ymcrc_pkg::PH_DONE;
                  end else begin
                    ph_nxt = ymcrc_pkg::PH_RECV; exp_nxt = 8'd1;
                    acc_nxt = '0; to_nxt = '0;
                  end
                end
              end else begin
                o.block_done = 1'b1;
                if (crc_full == crc_r && bn_r == exp_r &&
                    inv_sum == {1'b0, ymcrc_pkg::INV_SUM}) begin
                  o.block_good = 1'b1; o.response_byte = ymcrc_pkg::BYTE_ACK;
                  acc_nxt = acc_r + take; to_nxt = '0; exp_nxt = exp_r + 8'd1;
                end else begin
                  o.response_byte = ymcrc_pkg::BYTE_NAK;
                end
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    o.session_state = ph_nxt;
    o.decl_size = (ph_nxt == ymcrc_pkg::PH_IDLE || ph_nxt == ymcrc_pkg::PH_HEADER ||
                   ph_nxt == ymcrc_pkg::PH_HFAIL) ? 32'd0 : sz_nxt;
    o.rcvd_bytes = acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= ymcrc_pkg::PH_IDLE; fr_r <= ymcrc_pkg::FR_START; hf_r <= ymcrc_pkg::HF_NAME;
      pc_r <= '0; long_r <= 1'b0; bn_r <= '0; bi_r <= '0; exp_r <= 8'd1;
      to_r <= '0; ht_r <= '0; crc_r <= ymcrc_pkg::CRC_INIT; crx_r <= '0;
      sz_r <= '0; acc_r <= '0; rv_r <= 1'b0;
    end else begin
      if (fire) begin
        ph_r <= ph_nxt; fr_r <= fr_nxt; hf_r <= hf_nxt; pc_r <= pc_nxt;
        long_r <= long_nxt; bn_r <= bn_nxt; bi_r <= bi_nxt; exp_r <= exp_nxt;
        to_r <= to_nxt; ht_r <= ht_nxt; crc_r <= crc_nxt; crx_r <= crx_nxt;
        sz_r <= sz_nxt; acc_r <= acc_nxt;
      end
      if (fire) rv_r <= 1'b1;
      else if (res_ready) rv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= o;
  end

endmodule
